### rtl/core/qmu_pkg.sv
// Shared types, constants and tables for the QPSK mapper and upconverter.
`timescale 1ns / 1ps
package qmu_pkg;

   localparam int STEP_W       = 32;   // width of the phase step register
   localparam int ANGLE_W      = 32;   // angle in turns * 2^32
   localparam int WORK_FRAC    = 30;   // fraction bits of the rotation datapath
   localparam int DATA_W       = 33;   // x/y width: magnitude stays below 2^32
   localparam int Z_W          = 32;   // residual angle width
   localparam int SAMPLE_W     = 16;   // output sample width
   localparam int ATAN_COUNT   = 24;   // arctangent table depth

   localparam int PHASE_BITS_DEF       = 32;
   localparam int SAMPLE_FRAC_BITS_DEF = 14;
   localparam int CORDIC_STAGES_DEF    = 16;

   // 0.60725293 with 30 fraction bits
   localparam logic signed [DATA_W-1:0] GAIN_INV = 33'sd652032875;

   // Quadrant codes from the top two angle bits
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [Z_W-1:0]    z;
   } cell_vec_type;

   // atan(2^-i) in turns * 2^32
   function automatic logic signed [Z_W-1:0] atan_turns(input int idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         0:       val = 32'sd536870912;
         1:       val = 32'sd316933406;
         2:       val = 32'sd167458907;
         3:       val = 32'sd85004756;
         4:       val = 32'sd42667331;
         5:       val = 32'sd21354465;
         6:       val = 32'sd10679838;
         7:       val = 32'sd5340245;
         8:       val = 32'sd2670163;
         9:       val = 32'sd1335087;
         10:      val = 32'sd667544;
         11:      val = 32'sd333772;
         12:      val = 32'sd166886;
         13:      val = 32'sd83443;
         14:      val = 32'sd41722;
         15:      val = 32'sd20861;
         16:      val = 32'sd10430;
         17:      val = 32'sd5215;
         18:      val = 32'sd2608;
         19:      val = 32'sd1304;
         20:      val = 32'sd652;
         21:      val = 32'sd326;
         22:      val = 32'sd163;
         23:      val = 32'sd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

### rtl/core/qpsk_map_and_upconvert.sv
// Top level: QPSK symbol mapper with CORDIC carrier upconversion.
//
//   channel | direction | ports                                   | accepted when
//   req     | in        | req_chip_quad, req_chip_inphase,        | req_valid & !req_stall
//           |           | req_start_req                           |
//   rsp     | out       | rsp_sample                              | rsp_valid & !rsp_stall
//   csr     | in        | csr_wr_data (phase_step)                | csr_wr_en
//
// One symbol per clock while the output is not stalled; each symbol passes through the chain
// of CORDIC cells and then the rounding/output register.
// Synchronous reset clears the phase accumulator, the step register and all valid bits.
// While the output holds a transaction and rsp_stall is high, the whole chain freezes and
// req_stall is raised; otherwise req_stall is low.
`timescale 1ns / 1ps
module qpsk_map_and_upconvert #(
   parameter int PHASE_BITS       = qmu_pkg::PHASE_BITS_DEF,
   parameter int SAMPLE_FRAC_BITS = qmu_pkg::SAMPLE_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES    = qmu_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_chip_quad,
   input  logic                                req_chip_inphase,
   input  logic                                req_start_req,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [qmu_pkg::SAMPLE_W-1:0] rsp_sample,
   input  logic                                csr_wr_en,
   input  logic [qmu_pkg::STEP_W-1:0]          csr_wr_data
);

   localparam int NUM_CELLS = (CORDIC_STAGES > qmu_pkg::ATAN_COUNT) ?
                              qmu_pkg::ATAN_COUNT : CORDIC_STAGES;

   logic                  advance;
   qmu_pkg::cell_vec_type chain [0:NUM_CELLS];

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   qmu_phase_acc #(
      .PHASE_BITS (PHASE_BITS)
   ) u_phase (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .req_valid        (req_valid),
      .req_chip_quad    (req_chip_quad),
      .req_chip_inphase (req_chip_inphase),
      .req_start_req    (req_start_req),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .seed             (chain[0])
   );

   generate
      for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
         qmu_cordic_cell #(
            .STAGE (i)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
         );
      end
   endgenerate

   qmu_out_stage #(
      .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .cell_in    (chain[NUM_CELLS]),
      .rsp_valid  (rsp_valid),
      .rsp_sample (rsp_sample)
   );

endmodule

### rtl/core/qmu_phase_acc.sv
// Phase accumulator, step register and quarter-turn pre-rotation of the symbol.
`timescale 1ns / 1ps
module qmu_phase_acc #(
   parameter int PHASE_BITS = qmu_pkg::PHASE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          req_valid,
   input  logic                          req_chip_quad,
   input  logic                          req_chip_inphase,
   input  logic                          req_start_req,
   input  logic                          csr_wr_en,
   input  logic [qmu_pkg::STEP_W-1:0]    csr_wr_data,
   output qmu_pkg::cell_vec_type         seed
);

   logic [qmu_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [PHASE_BITS-1:0]       phase_ff, phase_in;
   logic [PHASE_BITS-1:0]       phase_used;
   logic [PHASE_BITS-1:0]       step_aligned;
   logic [qmu_pkg::ANGLE_W-1:0] angle;
   logic                        x_neg, y_neg;

   assign phase_used = req_start_req ? '0 : phase_ff;

   generate
      if (PHASE_BITS > qmu_pkg::STEP_W) begin : g_wide
         assign step_aligned = {step_ff, {(PHASE_BITS - qmu_pkg::STEP_W){1'b0}}};
         assign angle        = phase_used[PHASE_BITS-1 -: qmu_pkg::ANGLE_W];
      end else if (PHASE_BITS == qmu_pkg::STEP_W) begin : g_equal
         assign step_aligned = step_ff;
         assign angle        = phase_used;
      end else begin : g_narrow
         assign step_aligned = step_ff[qmu_pkg::STEP_W-1 -: PHASE_BITS];
         assign angle        = {phase_used, {(qmu_pkg::ANGLE_W - PHASE_BITS){1'b0}}};
      end
   endgenerate

   assign step_in  = csr_wr_en ? csr_wr_data : step_ff;
   assign phase_in = (req_valid && advance) ? phase_used + step_aligned : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         phase_ff <= '0;
      end else begin
         step_ff  <= step_in;
         phase_ff <= phase_in;
      end
   end

   // chip 1 -> -1; rotate (I, Q) by the quadrant exactly
   always_comb begin
      case (angle[qmu_pkg::ANGLE_W-1 -: 2])
         qmu_pkg::QUAD_0: begin x_neg = req_chip_inphase;  y_neg = req_chip_quad;     end
         qmu_pkg::QUAD_1: begin x_neg = !req_chip_quad;    y_neg = req_chip_inphase;  end
         qmu_pkg::QUAD_2: begin x_neg = !req_chip_inphase; y_neg = !req_chip_quad;    end
         default:         begin x_neg = req_chip_quad;     y_neg = !req_chip_inphase; end
      endcase
   end

   assign seed.valid = req_valid;
   assign seed.x     = x_neg ? -qmu_pkg::GAIN_INV : qmu_pkg::GAIN_INV;
   assign seed.y     = y_neg ? -qmu_pkg::GAIN_INV : qmu_pkg::GAIN_INV;
   assign seed.z     = {{(qmu_pkg::Z_W - qmu_pkg::ANGLE_W + 2){1'b0}},
                        angle[qmu_pkg::ANGLE_W-3:0]};

endmodule

### rtl/core/qmu_cordic_cell.sv
// One CORDIC rotation cell with its pipeline register.
`timescale 1ns / 1ps
module qmu_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  qmu_pkg::cell_vec_type cell_in,
   output qmu_pkg::cell_vec_type cell_out
);

   logic signed [qmu_pkg::DATA_W-1:0] x_cur, y_cur, dx, dy;
   logic signed [qmu_pkg::Z_W-1:0]    z_cur, atan_val;
   qmu_pkg::cell_vec_type             vec_ff, vec_in;

   assign x_cur    = cell_in.x;
   assign y_cur    = cell_in.y;
   assign z_cur    = cell_in.z;
   assign dx       = y_cur >>> STAGE;   // floor shift
   assign dy       = x_cur >>> STAGE;
   assign atan_val = qmu_pkg::atan_turns(STAGE);

   always_comb begin
      vec_in       = vec_ff;
      if (advance) begin
         vec_in.valid = cell_in.valid;
         if (!z_cur[qmu_pkg::Z_W-1]) begin
            vec_in.x = x_cur - dx;
            vec_in.y = y_cur + dy;
            vec_in.z = z_cur - atan_val;
         end else begin
            vec_in.x = x_cur + dx;
            vec_in.y = y_cur - dy;
            vec_in.z = z_cur + atan_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff <= '0;
      end else begin
         vec_ff <= vec_in;
      end
   end

   assign cell_out = vec_ff;

endmodule

### rtl/core/qmu_out_stage.sv
// Rounding, saturation and the output register.
`timescale 1ns / 1ps
module qmu_out_stage #(
   parameter int SAMPLE_FRAC_BITS = qmu_pkg::SAMPLE_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  qmu_pkg::cell_vec_type               cell_in,
   output logic                                rsp_valid,
   output logic signed [qmu_pkg::SAMPLE_W-1:0] rsp_sample
);

   localparam int SH  = qmu_pkg::WORK_FRAC - SAMPLE_FRAC_BITS;
   localparam int RW  = qmu_pkg::DATA_W + 1;
   localparam logic signed [RW-1:0] HALF = RW'(1) <<< (SH - 1);
   localparam logic signed [RW-1:0] SMAX = (RW'(1) <<< (qmu_pkg::SAMPLE_W - 1)) - RW'(1);
   localparam logic signed [RW-1:0] SMIN = -(RW'(1) <<< (qmu_pkg::SAMPLE_W - 1));

   logic signed [RW-1:0]               rounded, shifted;
   logic signed [qmu_pkg::SAMPLE_W-1:0] sat;
   logic                               valid_ff, valid_in;
   logic signed [qmu_pkg::SAMPLE_W-1:0] sample_ff, sample_in;

   assign rounded = {cell_in.x[qmu_pkg::DATA_W-1], cell_in.x} + HALF;
   assign shifted = rounded >>> SH;

   always_comb begin
      if (shifted > SMAX) begin
         sat = SMAX[qmu_pkg::SAMPLE_W-1:0];
      end else if (shifted < SMIN) begin
         sat = SMIN[qmu_pkg::SAMPLE_W-1:0];
      end else begin
         sat = shifted[qmu_pkg::SAMPLE_W-1:0];
      end
   end

   assign valid_in  = advance ? cell_in.valid : valid_ff;
   assign sample_in = advance ? sat : sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_sample = sample_ff;

endmodule

### rtl/core/qmu_checker.sv
// Port-level checks for the QPSK mapper and upconverter, bound to the top level.
`timescale 1ns / 1ps
module qmu_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [qmu_pkg::SAMPLE_W-1:0] rsp_sample
);

   // reset empties the output register
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample))
      else $error("stalled result transaction changed");

   // input back-pressure only comes from a full, stalled output
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not follow output back-pressure");

   // handshake outputs are always known; a result carries a known sample
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_stall, rsp_valid}) && (!rsp_valid || !$isunknown(rsp_sample)))
      else $error("unknown value on output ports");

endmodule

bind qpsk_map_and_upconvert qmu_checker u_qmu_checker (.*);

### tb/testbench.sv
// Self-checking testbench for the QPSK mapper with carrier upconversion.
`timescale 1ns / 1ps
module testbench;

   localparam int ROTATION_STAGES = qmu_pkg::CORDIC_STAGES_DEF;
   localparam int ROUND_SHIFT     = qmu_pkg::WORK_FRAC - qmu_pkg::SAMPLE_FRAC_BITS_DEF;
   localparam int PIPE_LATENCY    = ROTATION_STAGES + 1;
   localparam longint CORDIC_GAIN_COMP = 64'sd652032875;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic                                req_chip_quad = 1'b0;
   logic                                req_chip_inphase = 1'b0;
   logic                                req_start_req = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [qmu_pkg::SAMPLE_W-1:0] rsp_sample;
   logic                                csr_wr_en = 1'b0;
   logic [qmu_pkg::STEP_W-1:0]          csr_wr_data = '0;

   // carrier state as the block should hold it
   logic [31:0]                         carrier_phase_model = '0;
   logic [31:0]                         phase_step_model = '0;
   logic signed [qmu_pkg::SAMPLE_W-1:0] expected_samples[$];
   int                                  mismatch_count = 0;
   bit                                  sender_gaps = 1'b0;
   bit                                  receiver_gaps = 1'b0;

   qpsk_map_and_upconvert DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_chip_quad(req_chip_quad),
      .req_chip_inphase(req_chip_inphase),
      .req_start_req(req_start_req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sample(rsp_sample),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // atan(2^-i) in turns * 2^32
   function automatic longint arctan_turns(input int idx);
      case (idx)
         0:       return 536870912;
         1:       return 316933406;
         2:       return 167458907;
         3:       return 85004756;
         4:       return 42667331;
         5:       return 21354465;
         6:       return 10679838;
         7:       return 5340245;
         8:       return 2670163;
         9:       return 1335087;
         10:      return 667544;
         11:      return 333772;
         12:      return 166886;
         13:      return 83443;
         14:      return 41722;
         15:      return 20861;
         16:      return 10430;
         17:      return 5215;
         18:      return 2608;
         19:      return 1304;
         20:      return 652;
         21:      return 326;
         22:      return 163;
         23:      return 81;
         default: return 0;
      endcase
   endfunction

   // I*cos(angle) - Q*sin(angle) through quarter-turn swap plus CORDIC rotation
   function automatic logic signed [qmu_pkg::SAMPLE_W-1:0] upconverted_sample(
         input bit chip_q, input bit chip_i, input logic [31:0] angle);
      longint i0;
      longint q0;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      longint t;
      i0 = chip_i ? -CORDIC_GAIN_COMP : CORDIC_GAIN_COMP;
      q0 = chip_q ? -CORDIC_GAIN_COMP : CORDIC_GAIN_COMP;
      case (angle[31:30])
         qmu_pkg::QUAD_0: begin x = i0;  y = q0;  end
         qmu_pkg::QUAD_1: begin x = -q0; y = i0;  end
         qmu_pkg::QUAD_2: begin x = -i0; y = -q0; end
         default: begin x = q0; y = -i0; end
      endcase
      z = longint'(angle[29:0]);
      for (int i = 0; i < ROTATION_STAGES && i < qmu_pkg::ATAN_COUNT; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - arctan_turns(i);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + arctan_turns(i);
         end
      end
      t = (x + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      if (t > 32767)
         t = 32767;
      if (t < -32768)
         t = -32768;
      return t[qmu_pkg::SAMPLE_W-1:0];
   endfunction

   always @(posedge clock) begin
      rsp_stall <= receiver_gaps && ($urandom_range(0, 99) < 27);
   end

   // result checker
   always @(posedge clock) begin
      logic signed [qmu_pkg::SAMPLE_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected sample, expected none, actual %0d", $time, rsp_sample);
            mismatch_count++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample !== want) begin
               $display("%0t: sample mismatch, expected %0d, actual %0d",
                        $time, want, rsp_sample);
               mismatch_count++;
            end
         end
      end
   end

   task automatic send_symbol(input bit chip_q, input bit chip_i, input bit restart);
      logic [31:0] angle;
      while (sender_gaps && $urandom_range(0, 99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_chip_quad    <= chip_q;
      req_chip_inphase <= chip_i;
      req_start_req    <= restart;
      do @(posedge clock); while (req_stall);
      // transaction accepted at this edge
      angle = restart ? 32'd0 : carrier_phase_model;
      expected_samples.push_back(upconverted_sample(chip_q, chip_i, angle));
      carrier_phase_model = angle + phase_step_model;
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0)
         @(posedge clock);
   endtask

   task automatic program_phase_step(input logic [31:0] step);
      wait_until_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= step;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      phase_step_model = step;
   endtask

   task automatic send_random_symbols(input int count);
      for (int n = 0; n < count; n++)
         send_symbol(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 19) == 0);
   endtask

   // all chip pairs at phase zero, with and without restart
   task automatic test_zero_phase();
      program_phase_step(32'h0000_0000);
      for (int k = 0; k < 8; k++)
         send_symbol(k[0], k[1], k[2]);
   endtask

   // quarter-turn step walks every quadrant
   task automatic test_quadrants();
      program_phase_step(32'h4000_0000);
      for (int k = 0; k < 8; k++)
         send_symbol(k[1], k[0] ^ k[2], k == 0);
   endtask

   task automatic test_step_extremes();
      program_phase_step(32'hFFFF_FFFF);
      send_symbol(1'b0, 1'b0, 1'b1);
      send_symbol(1'b1, 1'b0, 1'b0);
      send_symbol(1'b0, 1'b1, 1'b0);
      send_symbol(1'b1, 1'b1, 1'b0);
      program_phase_step(32'h8000_0000);
      send_symbol(1'b0, 1'b1, 1'b0);
      send_symbol(1'b1, 1'b0, 1'b0);
      program_phase_step(32'h0000_0001);
      send_symbol(1'b1, 1'b1, 1'b1);
      send_symbol(1'b0, 1'b0, 1'b0);
      send_symbol(1'b1, 1'b0, 1'b0);
   endtask

   task automatic test_random_symbols();
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
      program_phase_step($urandom);
      send_random_symbols(250);
      program_phase_step($urandom_range(1, 32'h0100_0000));
      send_random_symbols(250);
      program_phase_step(32'hFFFF_FFFF - $urandom_range(0, 32'h00FF_FFFF));
      send_random_symbols(200);
      program_phase_step($urandom);
      send_random_symbols(200);
   endtask

   task automatic test_back_to_back();
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      program_phase_step($urandom);
      send_random_symbols(250);
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
   endtask

   // sender holds off until the pipeline is empty, then resumes mid-phase
   task automatic test_drain_pause();
      program_phase_step($urandom);
      send_random_symbols(60);
      wait_until_drained();
      send_random_symbols(60);
      program_phase_step(32'h0000_0000);
      send_random_symbols(40);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_phase();
      test_quadrants();
      test_step_extremes();
      test_random_symbols();
      test_back_to_back();
      test_drain_pause();
      wait_until_drained();
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0 && expected_samples.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
